// ===== rtl/core/i2c_sccb_pkg.sv =====
`default_nettype none

package i2c_sccb_pkg;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned STAGE_W = 4;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic REG_SCCB_MODE   = 1'b0;
  localparam logic REG_DELAY_TICKS = 1'b1;

  localparam logic [15:0] DELAY_TICKS_RESET = 16'd10;

  // bus phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST_A    = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST_B    = 5'd2;
  localparam logic [PHASE_W-1:0] PH_TX_LO   = 5'd3;
  localparam logic [PHASE_W-1:0] PH_TX_HI   = 5'd4;
  localparam logic [PHASE_W-1:0] PH_AK_LO   = 5'd5;
  localparam logic [PHASE_W-1:0] PH_AK_HI   = 5'd6;
  localparam logic [PHASE_W-1:0] PH_AK_TAIL = 5'd7;
  localparam logic [PHASE_W-1:0] PH_SP_A    = 5'd8;
  localparam logic [PHASE_W-1:0] PH_SP_B    = 5'd9;
  localparam logic [PHASE_W-1:0] PH_SP_C    = 5'd10;
  localparam logic [PHASE_W-1:0] PH_RD_PRE  = 5'd11;
  localparam logic [PHASE_W-1:0] PH_RD_W1   = 5'd12;
  localparam logic [PHASE_W-1:0] PH_RD_W2   = 5'd13;
  localparam logic [PHASE_W-1:0] PH_RD_HI   = 5'd14;
  localparam logic [PHASE_W-1:0] PH_RD_POST = 5'd15;
  localparam logic [PHASE_W-1:0] PH_MA_LO   = 5'd16;
  localparam logic [PHASE_W-1:0] PH_MA_HI   = 5'd17;
  localparam logic [PHASE_W-1:0] PH_MA_TAIL = 5'd18;

  // transaction stages
  localparam logic [STAGE_W-1:0] SG_START1  = 4'd0;
  localparam logic [STAGE_W-1:0] SG_ADDRW   = 4'd1;
  localparam logic [STAGE_W-1:0] SG_REG     = 4'd2;
  localparam logic [STAGE_W-1:0] SG_DATA    = 4'd3;
  localparam logic [STAGE_W-1:0] SG_MIDSTOP = 4'd4;
  localparam logic [STAGE_W-1:0] SG_START2  = 4'd5;
  localparam logic [STAGE_W-1:0] SG_ADDRR   = 4'd6;
  localparam logic [STAGE_W-1:0] SG_READ    = 4'd7;
  localparam logic [STAGE_W-1:0] SG_STOP    = 4'd8;

  typedef struct packed {
    logic       done_res;
    logic       ack_missing;
    logic       last_byte;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       sda_is_input;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_sccb_register_master_core.sv =====
`default_nettype none

// Bit-banged I2C / SCCB register master, advanced by one bus tick per input transaction.
// s_axis carries one tick each: the command (tick only, register write, register read),
// the request fields that a start command latches, and the sampled SDA level.
// m_axis returns exactly one result per tick: the SCL/SDA levels to drive, the SDA
// direction, busy, the received byte with its valid flag, missing-ack and done flags;
// tlast marks the final byte of a read. A command while busy is ignored.
// Configuration: wr_en/wr_index/wr_data write sccb_mode (index 0) or delay_ticks
// (index 1); write only while no tick is in flight.
// The result is registered: the whole tick update of the bus sequencer (segment counter
// compare and phase/stage step) sits between the state registers and the result
// register. The core takes one tick per cycle unless a stalled receiver holds it.
// A stalled receiver holds the result register; s_axis_tready is high whenever the
// result register is empty or being taken in the same cycle.
// Reset (rst, synchronous) returns the bus to idle with SCL and SDA high, clears the
// result valid flag and sets sccb_mode to 0 and delay_ticks to 10.
module i2c_sccb_register_master_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[1:0], device_address[8:2], register_address[16:9], write_data[24:17],
  // byte_count[32:25], sda_in[33], zeros[39:34]
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // scl_level[0], sda_level[1], sda_is_input[2], busy_res[3], read_byte[11:4],
  // byte_valid[12], ack_missing[13], done_res[14], zero[15]
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [15:0] wr_data
);

  localparam int unsigned PW = i2c_sccb_pkg::PHASE_W;
  localparam int unsigned SW = i2c_sccb_pkg::STAGE_W;

  logic        sccb_mode;
  logic [15:0] delay_ticks;

  logic [PW-1:0] phase, phase_next;
  logic [15:0]   delay_counter, delay_counter_next;
  logic [3:0]    bit_counter, bit_counter_next;
  logic [7:0]    bytes_left, bytes_left_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic [6:0]    req_dev, req_dev_next;
  logic [7:0]    req_reg, req_reg_next;
  logic [7:0]    req_data, req_data_next;
  logic [7:0]    req_count, req_count_next;
  logic          req_read, req_read_next;
  logic [SW-1:0] stage, stage_next;
  logic          sda_hold, sda_hold_next;

  i2c_sccb_pkg::result_t res, result;
  logic                  out_valid;

  logic        accept;
  logic [1:0]  in_command;
  logic        in_sda;
  logic [16:0] limit;
  logic        advance;
  logic        finish;
  logic [SW-1:0] next_stg;
  logic [PW-1:0] seg_phase;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_command    = s_axis_tdata[1:0];
  assign in_sda        = s_axis_tdata[33];
  assign limit         = (delay_ticks == 16'd0) ? 17'd1 : {1'b0, delay_ticks};

  // sda level held by a phase on entry
  function automatic logic enter_sda(input logic [PW-1:0] ph, input logic cur,
                                     input logic [7:0] sb, input logic [7:0] bl);
    logic v;
    v = cur;
    case (ph) inside
      i2c_sccb_pkg::PH_IDLE, i2c_sccb_pkg::PH_ST_A, i2c_sccb_pkg::PH_SP_C,
      i2c_sccb_pkg::PH_RD_W1:                          v = 1'b1;
      i2c_sccb_pkg::PH_ST_B, i2c_sccb_pkg::PH_SP_A:    v = 1'b0;
      i2c_sccb_pkg::PH_TX_LO:                          v = sb[7];
      i2c_sccb_pkg::PH_MA_HI:                          v = (bl > 8'd1) ? 1'b0 : 1'b1;
      default:                                         v = cur;
    endcase
    return v;
  endfunction

  always_comb begin
    phase_next         = phase;
    delay_counter_next = delay_counter;
    bit_counter_next   = bit_counter;
    bytes_left_next    = bytes_left;
    shift_byte_next    = shift_byte;
    req_dev_next       = req_dev;
    req_reg_next       = req_reg;
    req_data_next      = req_data;
    req_count_next     = req_count;
    req_read_next      = req_read;
    stage_next         = stage;
    sda_hold_next      = sda_hold;
    res                = '0;
    advance            = 1'b0;
    finish             = 1'b0;
    next_stg           = i2c_sccb_pkg::SG_START1;
    seg_phase          = phase;

    if (phase == i2c_sccb_pkg::PH_IDLE &&
        (in_command == i2c_sccb_pkg::CMD_WRITE || in_command == i2c_sccb_pkg::CMD_READ)) begin
      req_dev_next       = s_axis_tdata[8:2];
      req_reg_next       = s_axis_tdata[16:9];
      req_data_next      = s_axis_tdata[24:17];
      req_count_next     = s_axis_tdata[32:25];
      req_read_next      = (in_command == i2c_sccb_pkg::CMD_READ);
      stage_next         = i2c_sccb_pkg::SG_START1;
      phase_next         = i2c_sccb_pkg::PH_ST_A;
      delay_counter_next = 16'd0;
      sda_hold_next      = 1'b1;
    end

    case (phase_next) inside
      i2c_sccb_pkg::PH_TX_LO, i2c_sccb_pkg::PH_AK_LO, i2c_sccb_pkg::PH_AK_TAIL,
      i2c_sccb_pkg::PH_SP_A, i2c_sccb_pkg::PH_RD_PRE, i2c_sccb_pkg::PH_RD_W2,
      i2c_sccb_pkg::PH_RD_POST, i2c_sccb_pkg::PH_MA_LO, i2c_sccb_pkg::PH_MA_TAIL:
        res.scl_level = 1'b0;
      i2c_sccb_pkg::PH_RD_W1: res.scl_level = (bit_counter_next != 4'd0);
      default:                res.scl_level = 1'b1;
    endcase
    case (phase_next) inside
      i2c_sccb_pkg::PH_AK_LO, i2c_sccb_pkg::PH_AK_HI, i2c_sccb_pkg::PH_RD_W1,
      i2c_sccb_pkg::PH_RD_W2, i2c_sccb_pkg::PH_RD_HI:
        res.sda_is_input = 1'b1;
      default: res.sda_is_input = 1'b0;
    endcase
    res.sda_level = res.sda_is_input | sda_hold_next;
    res.busy_res  = (phase_next != i2c_sccb_pkg::PH_IDLE);

    if (res.busy_res) begin
      if ({1'b0, delay_counter_next} + 17'd1 >= limit) begin
        seg_phase = phase_next;
        unique case (seg_phase)
          i2c_sccb_pkg::PH_ST_A:  phase_next = i2c_sccb_pkg::PH_ST_B;
          i2c_sccb_pkg::PH_TX_LO: phase_next = i2c_sccb_pkg::PH_TX_HI;
          i2c_sccb_pkg::PH_TX_HI: begin
            shift_byte_next  = {shift_byte_next[6:0], 1'b0};
            bit_counter_next = bit_counter_next + 4'd1;
            phase_next = (bit_counter_next >= 4'd8) ? i2c_sccb_pkg::PH_AK_LO
                                                    : i2c_sccb_pkg::PH_TX_LO;
          end
          i2c_sccb_pkg::PH_AK_LO: phase_next = i2c_sccb_pkg::PH_AK_HI;
          i2c_sccb_pkg::PH_AK_HI: begin
            if (in_sda) begin
              res.ack_missing = 1'b1;
              advance         = 1'b1;
            end else begin
              phase_next = i2c_sccb_pkg::PH_AK_TAIL;
            end
          end
          i2c_sccb_pkg::PH_SP_A:   phase_next = i2c_sccb_pkg::PH_SP_B;
          i2c_sccb_pkg::PH_SP_B:   phase_next = i2c_sccb_pkg::PH_SP_C;
          i2c_sccb_pkg::PH_RD_PRE: phase_next = i2c_sccb_pkg::PH_RD_W1;
          i2c_sccb_pkg::PH_RD_W1:  phase_next = i2c_sccb_pkg::PH_RD_W2;
          i2c_sccb_pkg::PH_RD_W2:  phase_next = i2c_sccb_pkg::PH_RD_HI;
          i2c_sccb_pkg::PH_RD_HI: begin
            shift_byte_next  = {shift_byte_next[6:0], in_sda};
            bit_counter_next = bit_counter_next + 4'd1;
            if (bit_counter_next >= 4'd8) begin
              res.byte_valid = 1'b1;
              res.read_byte  = shift_byte_next;
              res.last_byte  = (bytes_left_next <= 8'd1);
              phase_next     = i2c_sccb_pkg::PH_RD_POST;
            end else begin
              phase_next = i2c_sccb_pkg::PH_RD_W1;
            end
          end
          i2c_sccb_pkg::PH_RD_POST: phase_next = i2c_sccb_pkg::PH_MA_LO;
          i2c_sccb_pkg::PH_MA_LO:   phase_next = i2c_sccb_pkg::PH_MA_HI;
          i2c_sccb_pkg::PH_MA_HI:   phase_next = i2c_sccb_pkg::PH_MA_TAIL;
          i2c_sccb_pkg::PH_MA_TAIL: begin
            if (bytes_left_next > 8'd0) bytes_left_next = bytes_left_next - 8'd1;
            if (bytes_left_next > 8'd0) begin
              shift_byte_next  = 8'd0;
              bit_counter_next = 4'd0;
              phase_next       = i2c_sccb_pkg::PH_RD_PRE;
            end else begin
              advance = 1'b1;
            end
          end
          i2c_sccb_pkg::PH_ST_B, i2c_sccb_pkg::PH_AK_TAIL, i2c_sccb_pkg::PH_SP_C:
            advance = 1'b1;
          default: phase_next = i2c_sccb_pkg::PH_IDLE;
        endcase

        if (advance) begin
          unique case (stage_next)
            i2c_sccb_pkg::SG_START1:  next_stg = i2c_sccb_pkg::SG_ADDRW;
            i2c_sccb_pkg::SG_ADDRW:   next_stg = i2c_sccb_pkg::SG_REG;
            i2c_sccb_pkg::SG_REG:
              next_stg = !req_read_next ? i2c_sccb_pkg::SG_DATA :
                         sccb_mode      ? i2c_sccb_pkg::SG_MIDSTOP : i2c_sccb_pkg::SG_START2;
            i2c_sccb_pkg::SG_DATA:    next_stg = i2c_sccb_pkg::SG_STOP;
            i2c_sccb_pkg::SG_MIDSTOP: next_stg = i2c_sccb_pkg::SG_START2;
            i2c_sccb_pkg::SG_START2:  next_stg = i2c_sccb_pkg::SG_ADDRR;
            i2c_sccb_pkg::SG_ADDRR:   next_stg = i2c_sccb_pkg::SG_READ;
            i2c_sccb_pkg::SG_READ:    next_stg = i2c_sccb_pkg::SG_STOP;
            default:                  finish   = 1'b1;
          endcase
          if (finish) begin
            res.done_res = 1'b1;
            stage_next   = i2c_sccb_pkg::SG_START1;
            phase_next   = i2c_sccb_pkg::PH_IDLE;
          end else begin
            stage_next = next_stg;
            case (next_stg) inside
              i2c_sccb_pkg::SG_START1, i2c_sccb_pkg::SG_START2:
                phase_next = i2c_sccb_pkg::PH_ST_A;
              i2c_sccb_pkg::SG_ADDRW, i2c_sccb_pkg::SG_REG, i2c_sccb_pkg::SG_DATA,
              i2c_sccb_pkg::SG_ADDRR: begin
                case (next_stg)
                  i2c_sccb_pkg::SG_ADDRW: shift_byte_next = {req_dev_next, 1'b0};
                  i2c_sccb_pkg::SG_REG:   shift_byte_next = req_reg_next;
                  i2c_sccb_pkg::SG_DATA:  shift_byte_next = req_data_next;
                  default:                shift_byte_next = {req_dev_next, 1'b1};
                endcase
                bit_counter_next = 4'd0;
                phase_next       = i2c_sccb_pkg::PH_TX_LO;
              end
              i2c_sccb_pkg::SG_MIDSTOP, i2c_sccb_pkg::SG_STOP:
                phase_next = i2c_sccb_pkg::PH_SP_A;
              i2c_sccb_pkg::SG_READ: begin
                // zero count reads one byte
                bytes_left_next  = (req_count_next == 8'd0) ? 8'd1 : req_count_next;
                shift_byte_next  = 8'd0;
                bit_counter_next = 4'd0;
                phase_next       = i2c_sccb_pkg::PH_RD_PRE;
              end
              default: phase_next = i2c_sccb_pkg::PH_IDLE;
            endcase
          end
        end

        delay_counter_next = 16'd0;
        sda_hold_next = enter_sda(phase_next, sda_hold_next, shift_byte_next,
                                  bytes_left_next);
      end else begin
        delay_counter_next = delay_counter_next + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sccb_mode   <= 1'b0;
      delay_ticks <= i2c_sccb_pkg::DELAY_TICKS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        i2c_sccb_pkg::REG_SCCB_MODE:   sccb_mode   <= wr_data[0];
        i2c_sccb_pkg::REG_DELAY_TICKS: delay_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= i2c_sccb_pkg::PH_IDLE;
      delay_counter <= 16'd0;
      bit_counter   <= 4'd0;
      bytes_left    <= 8'd0;
      shift_byte    <= 8'd0;
      req_dev       <= 7'd0;
      req_reg       <= 8'd0;
      req_data      <= 8'd0;
      req_count     <= 8'd0;
      req_read      <= 1'b0;
      stage         <= i2c_sccb_pkg::SG_START1;
      sda_hold      <= 1'b1;
    end else if (accept) begin
      phase         <= phase_next;
      delay_counter <= delay_counter_next;
      bit_counter   <= bit_counter_next;
      bytes_left    <= bytes_left_next;
      shift_byte    <= shift_byte_next;
      req_dev       <= req_dev_next;
      req_reg       <= req_reg_next;
      req_data      <= req_data_next;
      req_count     <= req_count_next;
      req_read      <= req_read_next;
      stage         <= stage_next;
      sda_hold      <= sda_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = result.last_byte;
  assign m_axis_tdata  = {1'b0, result.done_res, result.ack_missing, result.byte_valid,
                          result.read_byte, result.busy_res, result.sda_is_input,
                          result.sda_level, result.scl_level};

`ifndef SYNTH
  // a finishing transaction is still reported busy on its last tick
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && result.done_res |-> result.busy_res)
    else $error("done without busy");

  // byte fields are quiet unless a byte was just received
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !result.byte_valid |-> result.read_byte == 8'd0 && !m_axis_tlast)
    else $error("read byte fields set without byte_valid");

  // released data line reads back as high
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && result.sda_is_input |-> result.sda_level)
    else $error("sda low while released");

  // an idle sequencer has nothing latched in flight
  assert property (@(posedge clk) disable iff (rst)
    phase == i2c_sccb_pkg::PH_IDLE |-> delay_counter == 16'd0 && sda_hold)
    else $error("idle phase with live segment state");
`endif

endmodule

`default_nettype wire
